>>> src/vrth_pkg.sv
// ----------------------------------------------------------------------------
// vrth_pkg: shared widths and the item type for the vertical ray triangle hit
// Coordinate widths, derived product widths and the item handed from the
// front pipeline to the divider back end.
// ----------------------------------------------------------------------------
package vrth_pkg;

    // coordinate width (signed fixed point)
    localparam int CW     = 24;
    // edge and offset vectors
    localparam int DW     = CW + 1;
    // one 2D product
    localparam int PW     = 2 * DW;
    // cross product terms: det, u and v numerators
    localparam int XW     = PW + 1;
    // split of a cross term for the triple product multiply
    localparam int LB     = (XW + 1) / 2;
    localparam int HB     = XW - LB;
    // triple product numerator
    localparam int TW     = XW + DW + 2;
    // epsilon register
    localparam int EPS_W  = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // saturation limits of the height
    localparam logic [CW-1:0] H_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] H_MIN = {1'b1, {(CW-1){1'b0}}};

    // classified item: hit decision, sign and magnitudes for the division
    typedef struct packed {
        logic          hit;
        logic          neg;
        logic [XW-1:0] det;
        logic [TW-1:0] tmag;
    } t_job;

endpackage

>>> src/vrth_front.sv
// ----------------------------------------------------------------------------
// vrth_front: determinant, barycentric and height numerators
// Eight-stage pipeline: edges, 2D products, cross terms, split triple
// product, term sums, winding normalize, bounds classification.
// ----------------------------------------------------------------------------
module vrth_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic        [vrth_pkg::EPS_W-1:0] i_eps,
    input  logic signed [vrth_pkg::CW-1:0]   i_ray_x,
    input  logic signed [vrth_pkg::CW-1:0]   i_ray_z,
    input  logic signed [vrth_pkg::CW-1:0]   i_v0_x,
    input  logic signed [vrth_pkg::CW-1:0]   i_v0_y,
    input  logic signed [vrth_pkg::CW-1:0]   i_v0_z,
    input  logic signed [vrth_pkg::CW-1:0]   i_v1_x,
    input  logic signed [vrth_pkg::CW-1:0]   i_v1_y,
    input  logic signed [vrth_pkg::CW-1:0]   i_v1_z,
    input  logic signed [vrth_pkg::CW-1:0]   i_v2_x,
    input  logic signed [vrth_pkg::CW-1:0]   i_v2_y,
    input  logic signed [vrth_pkg::CW-1:0]   i_v2_z,
    output logic                             o_valid,
    output vrth_pkg::t_job                   o_job
);
    import vrth_pkg::*;

    localparam int NS = 8;

    logic [NS-1:0] r_vld;

    // stage 1: edges and ray offset
    logic signed [DW-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z, r_sx, r_sy, r_sz;
    // stage 2: products
    logic signed [PW-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7, r_m8, r_m9;
    logic signed [DW-1:0] r_e2_2 [3];
    // stage 3: cross terms
    logic signed [XW-1:0] r_det3, r_un3, r_q3 [3];
    logic signed [DW-1:0] r_e2_3 [3];
    // stage 4: partial products of the triple product
    logic signed [DW+LB:0]   r_plo [3];
    logic signed [DW+HB-1:0] r_phi [3];
    logic signed [XW-1:0]    r_det4, r_un4, r_vn4;
    // stage 5: terms
    logic signed [TW-1:0] r_term [3];
    logic signed [XW-1:0] r_det5, r_un5, r_vn5;
    // stage 6: numerator
    logic signed [TW-1:0] r_tn6;
    logic signed [XW-1:0] r_det6, r_un6, r_vn6;
    // stage 7: winding normalized
    logic signed [TW-1:0] r_tn7;
    logic signed [XW-1:0] r_det7, r_un7, r_vn7;
    // stage 8: classified item
    t_job r_job;

    logic signed [XW:0] w_uv;
    logic               w_hit;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        r_e1x <= DW'(i_v1_x) - DW'(i_v0_x);
        r_e1y <= DW'(i_v1_y) - DW'(i_v0_y);
        r_e1z <= DW'(i_v1_z) - DW'(i_v0_z);
        r_e2x <= DW'(i_v2_x) - DW'(i_v0_x);
        r_e2y <= DW'(i_v2_y) - DW'(i_v0_y);
        r_e2z <= DW'(i_v2_z) - DW'(i_v0_z);
        r_sx  <= DW'(i_ray_x) - DW'(i_v0_x);
        r_sy  <= -DW'(i_v0_y);
        r_sz  <= DW'(i_ray_z) - DW'(i_v0_z);
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        r_m0 <= r_e1x * r_e2z;
        r_m1 <= r_e1z * r_e2x;
        r_m2 <= r_sx * r_e2z;
        r_m3 <= r_sz * r_e2x;
        r_m4 <= r_sy * r_e1z;
        r_m5 <= r_sz * r_e1y;
        r_m6 <= r_sz * r_e1x;
        r_m7 <= r_sx * r_e1z;
        r_m8 <= r_sx * r_e1y;
        r_m9 <= r_sy * r_e1x;
        r_e2_2[0] <= r_e2x;
        r_e2_2[1] <= r_e2y;
        r_e2_2[2] <= r_e2z;
    end

    // stage 3: det, u numerator and q = s x e1
    always_ff @(posedge i_clk) begin
        r_det3  <= XW'(r_m0) - XW'(r_m1);
        r_un3   <= XW'(r_m2) - XW'(r_m3);
        r_q3[0] <= XW'(r_m4) - XW'(r_m5);
        r_q3[1] <= XW'(r_m6) - XW'(r_m7);
        r_q3[2] <= XW'(r_m8) - XW'(r_m9);
        r_e2_3  <= r_e2_2;
    end

    // stage 4: e2 . q, each term split into low and high halves
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_plo[k] <= r_e2_3[k] * $signed({1'b0, r_q3[k][LB-1:0]});
            r_phi[k] <= r_e2_3[k] * $signed(r_q3[k][XW-1:LB]);
        end
        r_det4 <= r_det3;
        r_un4  <= r_un3;
        r_vn4  <= r_q3[1];
    end

    // stage 5: rejoin halves
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_term[k] <= (TW'(r_phi[k]) <<< LB) + TW'(r_plo[k]);
        end
        r_det5 <= r_det4;
        r_un5  <= r_un4;
        r_vn5  <= r_vn4;
    end

    // stage 6: triple product
    always_ff @(posedge i_clk) begin
        r_tn6  <= r_term[0] + r_term[1] + r_term[2];
        r_det6 <= r_det5;
        r_un6  <= r_un5;
        r_vn6  <= r_vn5;
    end

    // stage 7: flip sign for the opposite winding
    always_ff @(posedge i_clk) begin
        if (r_det6[XW-1]) begin
            r_det7 <= -r_det6;
            r_un7  <= -r_un6;
            r_vn7  <= -r_vn6;
            r_tn7  <= -r_tn6;
        end else begin
            r_det7 <= r_det6;
            r_un7  <= r_un6;
            r_vn7  <= r_vn6;
            r_tn7  <= r_tn6;
        end
    end

    // stage 8: degenerate and barycentric bounds; edges count as hits
    assign w_uv  = (XW+1)'(r_un7) + (XW+1)'(r_vn7);
    assign w_hit = (r_det7 != '0)
                && !($unsigned(r_det7) < XW'(i_eps))
                && !r_un7[XW-1] && !(r_det7 < r_un7)
                && !r_vn7[XW-1] && !((XW+1)'(r_det7) < w_uv);

    always_ff @(posedge i_clk) begin
        r_job.hit  <= w_hit;
        r_job.neg  <= r_tn7[TW-1];
        r_job.det  <= $unsigned(r_det7);
        r_job.tmag <= r_tn7[TW-1] ? $unsigned(-r_tn7) : $unsigned(r_tn7);
    end

    assign o_valid = r_vld[NS-1];
    assign o_job   = r_job;

endmodule

>>> src/vrth_queue.sv
// ----------------------------------------------------------------------------
// vrth_queue: short item queue between front and back
// Register file with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module vrth_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vrth_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output vrth_pkg::t_job o_job
);
    import vrth_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_cnt;
    logic           w_push, w_pop;

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_job;
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_job   = r_mem[r_rptr];

endmodule

>>> src/vrth_back.sv
// ----------------------------------------------------------------------------
// vrth_back: height division and saturation
// Overflow check, one restoring division stage per quotient bit, then the
// sign, saturation and result register.
// ----------------------------------------------------------------------------
module vrth_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  vrth_pkg::t_job                 i_job,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic signed [vrth_pkg::CW-1:0] o_height,
    output logic                           o_height_clipped
);
    import vrth_pkg::*;

    logic [CW:0]   r_vld;
    logic          r_hit [CW+1];
    logic          r_neg [CW+1];
    logic          r_ov  [CW+1];
    logic [XW-1:0] r_det [CW+1];
    logic [TW-1:0] r_rem [CW+1];
    logic [CW-1:0] r_q   [CW+1];

    logic                 r_out_vld, r_out_hit, r_out_clip;
    logic signed [CW-1:0] r_out_h;
    logic                 w_clip;
    logic [CW-1:0]        w_h;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[CW-1:0], i_valid};
            r_out_vld <= r_vld[CW];
        end
    end

    // entry: quotient of 2^CW or more saturates whatever its low bits
    always_ff @(posedge i_clk) begin
        r_hit[0] <= i_job.hit;
        r_neg[0] <= i_job.neg;
        r_ov[0]  <= i_job.tmag >= (TW'(i_job.det) << CW);
        r_det[0] <= i_job.det;
        r_rem[0] <= i_job.tmag;
        r_q[0]   <= '0;
    end

    // one quotient bit per stage, MSB first
    for (genvar s = 0; s < CW; s++) begin : g_div
        localparam int B = CW - 1 - s;
        logic [TW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = TW'(r_det[s]) << B;
        assign w_ge = r_rem[s] >= w_sh;
        always_ff @(posedge i_clk) begin
            r_hit[s+1] <= r_hit[s];
            r_neg[s+1] <= r_neg[s];
            r_ov[s+1]  <= r_ov[s];
            r_det[s+1] <= r_det[s];
            r_rem[s+1] <= w_ge ? (r_rem[s] - w_sh) : r_rem[s];
            r_q[s+1]   <= r_q[s] | (CW'(w_ge) << B);
        end
    end

    // sign and saturation; exactly -2^(CW-1) is still in range
    always_comb begin
        if (r_neg[CW]) begin
            w_clip = r_ov[CW] || (r_q[CW][CW-1] && (r_q[CW][CW-2:0] != '0));
            w_h    = w_clip ? H_MIN : -r_q[CW];
        end else begin
            w_clip = r_ov[CW] || r_q[CW][CW-1];
            w_h    = w_clip ? H_MAX : r_q[CW];
        end
    end

    // result register; miss gives zero fields
    always_ff @(posedge i_clk) begin
        r_out_hit  <= r_hit[CW];
        r_out_clip <= r_hit[CW] && w_clip;
        r_out_h    <= r_hit[CW] ? $signed(w_h) : '0;
    end

    assign o_valid          = r_out_vld;
    assign o_hit            = r_out_hit;
    assign o_height         = r_out_h;
    assign o_height_clipped = r_out_clip;

`ifndef SYNTH
    a_clip_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_height_clipped |-> o_hit)
        else $error("clipped flag on a miss");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_height == '0) && !o_height_clipped)
        else $error("miss with nonzero height");

    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_height_clipped |-> (o_height == H_MAX) || (o_height == H_MIN))
        else $error("clipped height not at a limit");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##(CW+2) o_valid)
        else $error("item lost in divider");
`endif

endmodule

>>> src/vertical_ray_triangle_hit.sv
// ----------------------------------------------------------------------------
// vertical_ray_triangle_hit: vertical ray versus triangle, fixed point
// Channel    | handshake             | payload
// -----------+-----------------------+------------------------------------
// command    | start / busy          | i_ray_x, i_ray_z, i_v0..i_v2 x/y/z
// result     | o_valid (one cycle)   | o_hit, o_height, o_height_clipped
// config     | i_cfg_we              | i_cfg_data (det epsilon)
//
// One item per cycle sustained. An item passes through 8 front pipeline
// stages, the queue register, the overflow stage, 24 division stages (one
// per quotient bit) and the result register.
// Reset is synchronous, active low; epsilon resets to 1.
// The back end never stalls, so busy stays low in normal use.
// ----------------------------------------------------------------------------
module vertical_ray_triangle_hit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic        [vrth_pkg::EPS_W-1:0]   i_cfg_data,
    input  logic signed [vrth_pkg::CW-1:0]      i_ray_x,
    input  logic signed [vrth_pkg::CW-1:0]      i_ray_z,
    input  logic signed [vrth_pkg::CW-1:0]      i_v0_x,
    input  logic signed [vrth_pkg::CW-1:0]      i_v0_y,
    input  logic signed [vrth_pkg::CW-1:0]      i_v0_z,
    input  logic signed [vrth_pkg::CW-1:0]      i_v1_x,
    input  logic signed [vrth_pkg::CW-1:0]      i_v1_y,
    input  logic signed [vrth_pkg::CW-1:0]      i_v1_z,
    input  logic signed [vrth_pkg::CW-1:0]      i_v2_x,
    input  logic signed [vrth_pkg::CW-1:0]      i_v2_y,
    input  logic signed [vrth_pkg::CW-1:0]      i_v2_z,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic signed [vrth_pkg::CW-1:0]      o_height,
    output logic                                o_height_clipped
);
    import vrth_pkg::*;

    logic [EPS_W-1:0] r_det_epsilon;
    logic             w_accept, w_f_vld, w_q_vld, w_q_full;
    t_job             w_f_job, w_q_job;

    // epsilon register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_epsilon <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_det_epsilon <= i_cfg_data;
        end
    end

    assign busy     = w_q_full;
    assign w_accept = start && !busy;

    vrth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_eps   (r_det_epsilon),
        .i_ray_x (i_ray_x),
        .i_ray_z (i_ray_z),
        .i_v0_x  (i_v0_x),
        .i_v0_y  (i_v0_y),
        .i_v0_z  (i_v0_z),
        .i_v1_x  (i_v1_x),
        .i_v1_y  (i_v1_y),
        .i_v1_z  (i_v1_z),
        .i_v2_x  (i_v2_x),
        .i_v2_y  (i_v2_y),
        .i_v2_z  (i_v2_z),
        .o_valid (w_f_vld),
        .o_job   (w_f_job)
    );

    // back end drains the queue every cycle
    vrth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_vld),
        .i_job   (w_f_job),
        .i_pop   (w_q_vld),
        .o_valid (w_q_vld),
        .o_full  (w_q_full),
        .o_job   (w_q_job)
    );

    vrth_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_q_vld),
        .i_job            (w_q_job),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_height         (o_height),
        .o_height_clipped (o_height_clipped)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for vertical_ray_triangle_hit
// Drives triangle/ray items through the start/busy command port, predicts
// hit, height and clip flag with exact 128-bit integer math, and checks each
// strobed result in order. Epsilon is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
    import vrth_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [CW-1:0] C_MAX = H_MAX;
    localparam logic signed [CW-1:0] C_MIN = H_MIN;

    typedef struct {
        logic signed [CW-1:0] ray_x, ray_z;
        logic signed [CW-1:0] v0_x, v0_y, v0_z;
        logic signed [CW-1:0] v1_x, v1_y, v1_z;
        logic signed [CW-1:0] v2_x, v2_y, v2_z;
    } t_tri_item;

    typedef struct {
        logic                 hit;
        logic signed [CW-1:0] height;
        logic                 clipped;
    } t_hit_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [EPS_W-1:0]     i_cfg_data = '0;
    logic signed [CW-1:0] i_ray_x = '0, i_ray_z = '0;
    logic signed [CW-1:0] i_v0_x = '0, i_v0_y = '0, i_v0_z = '0;
    logic signed [CW-1:0] i_v1_x = '0, i_v1_y = '0, i_v1_z = '0;
    logic signed [CW-1:0] i_v2_x = '0, i_v2_y = '0, i_v2_z = '0;
    logic                 o_valid;
    logic                 o_hit;
    logic signed [CW-1:0] o_height;
    logic                 o_height_clipped;

    t_hit_result      pending_hits[$];
    logic [EPS_W-1:0] cur_eps = EPS_RESET;
    int               n_errors = 0;
    int               n_items = 0;
    int               n_hits_seen = 0;
    int               n_results = 0;
    bit               no_idle = 0;

    vertical_ray_triangle_hit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_ray_x(i_ray_x), .i_ray_z(i_ray_z),
        .i_v0_x(i_v0_x), .i_v0_y(i_v0_y), .i_v0_z(i_v0_z),
        .i_v1_x(i_v1_x), .i_v1_y(i_v1_y), .i_v1_z(i_v1_z),
        .i_v2_x(i_v2_x), .i_v2_y(i_v2_y), .i_v2_z(i_v2_z),
        .o_valid(o_valid), .o_hit(o_hit), .o_height(o_height),
        .o_height_clipped(o_height_clipped)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // exact hit test: determinant, barycentric numerators, height quotient
    function automatic t_hit_result ray_hit(t_tri_item t, logic [EPS_W-1:0] eps);
        logic signed [127:0] ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [127:0] sx, sy, sz, det, un, vn, tn, qx, qy, qz, h, epsw;
        t_hit_result r;
        ax = t.v0_x; ay = t.v0_y; az = t.v0_z;
        e1x = t.v1_x; e1y = t.v1_y; e1z = t.v1_z;
        e2x = t.v2_x; e2y = t.v2_y; e2z = t.v2_z;
        sx = t.ray_x; sz = t.ray_z;
        e1x = e1x - ax; e1y = e1y - ay; e1z = e1z - az;
        e2x = e2x - ax; e2y = e2y - ay; e2z = e2z - az;
        sx = sx - ax; sy = -ay; sz = sz - az;
        epsw = {112'd0, eps};
        det = e1x * e2z - e1z * e2x;
        un = sx * e2z - sz * e2x;
        qx = sy * e1z - sz * e1y;
        qy = sz * e1x - sx * e1z;
        qz = sx * e1y - sy * e1x;
        tn = e2x * qx + e2y * qy + e2z * qz;
        vn = qy;
        // fold the winding so the bounds read the same either way
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        r = '{1'b0, '0, 1'b0};
        if (det != 0 && det >= epsw && un >= 0 && un <= det && vn >= 0
                && un + vn <= det) begin
            h = tn / det;
            r.hit = 1'b1;
            if (h > 128'(signed'(C_MAX))) begin
                h = 128'(signed'(C_MAX)); r.clipped = 1'b1;
            end else if (h < 128'(signed'(C_MIN))) begin
                h = 128'(signed'(C_MIN)); r.clipped = 1'b1;
            end
            r.height = h[CW-1:0];
        end
        return r;
    endfunction

    function automatic t_tri_item mk(int rx, int rz, int ax, int ay, int az,
                                     int bx, int by, int bz, int cx, int cy, int cz);
        t_tri_item t;
        t.ray_x = CW'(rx); t.ray_z = CW'(rz);
        t.v0_x = CW'(ax); t.v0_y = CW'(ay); t.v0_z = CW'(az);
        t.v1_x = CW'(bx); t.v1_y = CW'(by); t.v1_z = CW'(bz);
        t.v2_x = CW'(cx); t.v2_y = CW'(cy); t.v2_z = CW'(cz);
        return t;
    endfunction

    // drive one item, hold it until accepted, then maybe idle
    task automatic send_item(t_tri_item t);
        int gap, pick;
        @(negedge i_clk);
        start <= 1'b1;
        i_ray_x <= t.ray_x; i_ray_z <= t.ray_z;
        i_v0_x <= t.v0_x; i_v0_y <= t.v0_y; i_v0_z <= t.v0_z;
        i_v1_x <= t.v1_x; i_v1_y <= t.v1_y; i_v1_z <= t.v1_z;
        i_v2_x <= t.v2_x; i_v2_y <= t.v2_y; i_v2_z <= t.v2_z;
        // busy only moves at rising edges, so mid-cycle it shows the edge value
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_hits.push_back(ray_hit(t, cur_eps));
        n_items++;
        pick = $urandom_range(0, 99);
        gap = no_idle ? 0 : (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 60);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // wait for all results, let the pipeline empty, then write epsilon
    task automatic set_epsilon(logic [EPS_W-1:0] val);
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_eps = val;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_hit_result exp_r;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (o_hit) n_hits_seen++;
            if (pending_hits.size() == 0) begin
                $error("unexpected result: hit=%0b height=%0d", o_hit, o_height);
                n_errors++;
            end else begin
                exp_r = pending_hits.pop_front();
                if (o_hit !== exp_r.hit) begin
                    $error("hit: expected %0b actual %0b", exp_r.hit, o_hit);
                    n_errors++;
                end
                if (o_height !== exp_r.height) begin
                    $error("height: expected %0d actual %0d", exp_r.height, o_height);
                    n_errors++;
                end
                if (o_height_clipped !== exp_r.clipped) begin
                    $error("height_clipped: expected %0b actual %0b",
                           exp_r.clipped, o_height_clipped);
                    n_errors++;
                end
            end
        end
    end

    // hand-picked triangles: windings, edges, corners, degenerate, extremes
    task automatic test_directed();
        int mx, mn;
        mx = 8388607; mn = -8388608;
        send_item(mk(64, 64, 0, 0, 0, 256, 100, 0, 0, 200, 256));
        send_item(mk(64, 64, 0, 0, 0, 0, 200, 256, 256, 100, 0));
        send_item(mk(256, 0, 0, 0, 0, 256, 100, 0, 0, 200, 256));
        send_item(mk(128, 128, 0, 0, 0, 256, 100, 0, 0, 200, 256));
        send_item(mk(300, 300, 0, 0, 0, 256, 100, 0, 0, 200, 256));
        send_item(mk(-1, 10, 0, 0, 0, 256, 100, 0, 0, 200, 256));
        send_item(mk(10, 10, 0, 5, 0, 100, 5, 100, 200, 5, 200));
        send_item(mk(0, 0, 0, 0, 0, 1, 5, 0, 0, 7, 1));
        send_item(mk(1, 0, 0, 0, 0, 1, -5, 0, 0, 7, 1));
        send_item(mk(33, 17, 0, -1000, 0, 100, 333, 0, 0, -777, 100));
        send_item(mk(mn, mn, mn, mn, mn, mx, mx, mn, mn, mx, mx));
        send_item(mk(mx, mn, mn, mn, mn, mx, mx, mn, mn, mx, mx));
        send_item(mk(mn, mx, mn, mx, mn, mx, mn, mn, mn, mn, mx));
        send_item(mk(0, 0, mn, mx, mn, mx, mx, mn, mn, mx, mx));
        send_item(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_item(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_item(mk(-5, -5, -10, 3, -10, 10, 3, -10, -10, 3, 10));
    endtask

    // the same shapes against zero and the largest epsilon
    task automatic test_epsilon_extremes();
        set_epsilon('0);
        test_directed();
        set_epsilon('1);
        test_directed();
        send_item(mk(10, 10, 0, 0, 0, 256, 9, 0, 0, 9, 255));
        send_item(mk(10, 10, 0, 0, 0, 256, 9, 0, 0, 9, 256));
    endtask

    function automatic int clamp_coord(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return int'(v);
    endfunction

    // random triangles, mostly with the ray inside or on the boundary
    function automatic t_tri_item random_tri();
        t_tri_item t;
        int rad, cx, cz, kind, sel;
        int px[3], py[3], pz[3];
        longint w[3], sx, sz;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
            return t;
        end
        sel = $urandom_range(0, 9);
        rad = (sel < 3) ? 4 : (sel < 6) ? 300 : (sel < 9) ? 20000 : 4000000;
        cx = $urandom_range(0, 2 * (8388607 - rad)) - (8388607 - rad);
        cz = $urandom_range(0, 2 * (8388607 - rad)) - (8388607 - rad);
        for (int i = 0; i < 3; i++) begin
            px[i] = cx + $urandom_range(0, 2 * rad) - rad;
            pz[i] = cz + $urandom_range(0, 2 * rad) - rad;
            py[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                                : $urandom_range(0, 2000) - 1000;
        end
        w[0] = $urandom_range(0, 1024);
        w[1] = $urandom_range(0, 1024 - w[0]);
        w[2] = 1024 - w[0] - w[1];
        // boundary items: drop one or two weights to hit an edge or corner
        if (kind >= 75) begin
            sel = $urandom_range(0, 2);
            w[(sel + 1) % 3] += w[sel];
            w[sel] = 0;
            if (kind >= 90) begin
                w[(sel + 2) % 3] += w[(sel + 1) % 3];
                w[(sel + 1) % 3] = 0;
            end
        end
        sx = 0; sz = 0;
        for (int i = 0; i < 3; i++) begin
            sx += w[i] * px[i];
            sz += w[i] * pz[i];
        end
        t = mk(clamp_coord(sx / 1024 + (kind % 3) - 1),
               clamp_coord(sz / 1024 + (kind % 5 == 0)),
               px[0], py[0], pz[0], px[1], py[1], pz[1], px[2], py[2], pz[2]);
        return t;
    endfunction

    task automatic test_random();
        logic [EPS_W-1:0] eps_list[7];
        eps_list = '{16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd0, 16'd0, 16'd0};
        eps_list[4] = EPS_W'($urandom_range(3, 255));
        eps_list[5] = EPS_W'($urandom);
        eps_list[6] = EPS_W'($urandom_range(256, 4095));
        for (int b = 0; b < 7; b++) begin
            set_epsilon(eps_list[b]);
            for (int i = 0; i < 250; i++) begin
                if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
                send_item(random_tri());
            end
        end
        no_idle = 0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_epsilon_extremes();
        test_random();
        @(negedge i_clk);
        start <= 1'b0;
        wait (pending_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d items sent, %0d results checked, %0d hits",
                 n_items, n_results, n_hits_seen);
        $display("tb_top: epsilon swept over 0, 1, 2, max and random values");
        if (n_errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
